// ===== sv/u16rb_pkg.sv =====
// ----------------------------------------------------------------------------
// u16rb_pkg
// Shared types, constants and helper functions for the UTF-16 deque store.
// ----------------------------------------------------------------------------
package u16rb_pkg;

  // Store geometry (power of two, so index wrap is a plain truncation)
  localparam int DEPTH  = 1024;
  localparam int AW     = $clog2(DEPTH);
  localparam int FW     = AW + 1;
  localparam int UNIT_W = 16;
  localparam int CP_W   = 21;

  // Commands
  typedef enum logic [2:0] {
    CMD_PUSH_CP_TAIL = 3'd0,
    CMD_PUSH_CP_HEAD = 3'd1,
    CMD_POP_CP_HEAD  = 3'd2,
    CMD_POP_CP_TAIL  = 3'd3,
    CMD_PUSH_U_TAIL  = 3'd4,
    CMD_PUSH_U_HEAD  = 3'd5,
    CMD_POP_U_HEAD   = 3'd6,
    CMD_POP_U_TAIL   = 3'd7
  } cmd_t;

  // Result status
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_SHORT     = 3'd2,
    ST_INVALID   = 3'd3,
    ST_MALFORMED = 3'd4
  } status_t;

  // Offset applied to a ring index by the shared index unit
  typedef enum logic [1:0] {
    STEP_P0 = 2'd0,
    STEP_P1 = 2'd1,
    STEP_M1 = 2'd2,
    STEP_M2 = 2'd3
  } step_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE  = 3'd0,
    S_FIRST = 3'd1,
    S_SECOND = 3'd2,
    S_EXAM  = 3'd3,
    S_EXAM2 = 3'd4
  } state_t;

  // Encoder result for one code point
  typedef struct packed {
    logic              invalid;
    logic              pair;
    logic [UNIT_W-1:0] u0;
    logic [UNIT_W-1:0] u1;
  } enc_t;

  function automatic logic is_high(input logic [UNIT_W-1:0] u);
    return u[15:10] == 6'b110110;
  endfunction

  function automatic logic is_low(input logic [UNIT_W-1:0] u);
    return u[15:10] == 6'b110111;
  endfunction

  // Surrogate pair to code point
  function automatic logic [CP_W-1:0] pair_value(input logic [UNIT_W-1:0] hi,
                                                 input logic [UNIT_W-1:0] lo);
    return CP_W'(21'h10000) + {1'b0, hi[9:0], lo[9:0]};
  endfunction

endpackage

// ===== sv/u16rb_ram.sv =====
// ----------------------------------------------------------------------------
// u16rb_ram
// Single-port unit store: one write or one read per cycle, registered read.
// ----------------------------------------------------------------------------
module u16rb_ram import u16rb_pkg::*; (
  input  logic              clk,
  input  logic              we,
  input  logic              re,
  input  logic [AW-1:0]     addr,
  input  logic [UNIT_W-1:0] wdata,
  output logic [UNIT_W-1:0] rdata
);

  logic [UNIT_W-1:0] mem [DEPTH];
  logic [UNIT_W-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/u16rb_idx.sv =====
// ----------------------------------------------------------------------------
// u16rb_idx
// Shared ring index unit: base index plus a small signed offset, mod DEPTH.
// ----------------------------------------------------------------------------
module u16rb_idx import u16rb_pkg::*; (
  input  logic [AW-1:0] base,
  input  step_t         step,
  output logic [AW-1:0] idx
);

  logic [AW-1:0] offset;

  // Offset in two's complement; wrap comes from truncation
  always_comb begin
    unique case (step)
      STEP_P0: offset = '0;
      STEP_P1: offset = AW'(1);
      STEP_M1: offset = '1;
      STEP_M2: offset = ~AW'(1);
      default: offset = '0;
    endcase
  end

  assign idx = base + offset;

endmodule

// ===== sv/u16rb_codec.sv =====
// ----------------------------------------------------------------------------
// u16rb_codec
// UTF-16 encoder: validity check and split into one unit or a surrogate pair.
// ----------------------------------------------------------------------------
module u16rb_codec import u16rb_pkg::*; (
  input  logic [CP_W-1:0] code_point,
  output enc_t            enc
);

  logic [CP_W-1:0] v;

  assign v = code_point - CP_W'(21'h10000);

  always_comb begin
    // above U+10FFFF or in the surrogate range
    enc.invalid = (code_point > CP_W'(21'h10FFFF)) ||
                  ((code_point >= CP_W'(21'h0D800)) && (code_point <= CP_W'(21'h0DFFF)));
    enc.pair    = code_point >= CP_W'(21'h10000);
    if (enc.pair) begin
      enc.u0 = {6'b110110, v[19:10]};
      enc.u1 = {6'b110111, v[9:0]};
    end else begin
      enc.u0 = code_point[UNIT_W-1:0];
      enc.u1 = '0;
    end
  end

endmodule

// ===== sv/utf16_double_ended_ring_buffer.sv =====
// ----------------------------------------------------------------------------
// utf16_double_ended_ring_buffer
// Ring store of 16-bit code units used as a deque, with UTF-16 encode/decode.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: an item is taken when start is high and busy is low.
//   in_command picks push/pop, code point/raw unit, head/tail end.
//   Result channel: out_valid pulses for one cycle with status, decoded
//   code point, raw unit, units moved and the fill level after the command.
//   The receiver cannot stall; each result is shown exactly once.
// Steps per command (the result strobe shows in the idle state after the last step):
//   S_FIRST only: single-unit push, any failed push, pop from an empty store.
//   S_FIRST, S_SECOND: surrogate pair push. S_FIRST, S_EXAM: raw unit pop, code point pop that ends
//             on its first unit (one unit decoded, malformed or too short).
//   S_FIRST, S_EXAM, S_EXAM2: code point pop that reads a second unit (pair or malformed).
//   The steps are set by the single-port unit memory: one unit is written or
//   read per cycle, and reads return in the next cycle through a register.
// Reset: synchronous active-low rst_n empties the store (head, tail and fill
//   go to zero); the unit memory itself is not cleared.
// ----------------------------------------------------------------------------
module utf16_double_ended_ring_buffer import u16rb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        in_command,
  input  logic [CP_W-1:0]   in_code_point,
  input  logic [UNIT_W-1:0] in_unit_in,
  output logic              out_valid,
  output logic [2:0]        out_status,
  output logic [CP_W-1:0]   out_decoded_point,
  output logic [UNIT_W-1:0] out_unit_out,
  output logic [1:0]        out_units_moved,
  output logic [FW-1:0]     out_fill_level
);

  state_t            state_r, state_nxt;
  cmd_t              cmd_r;
  logic [CP_W-1:0]   cp_r;
  logic [UNIT_W-1:0] uin_r;
  logic [AW-1:0]     head_r, head_nxt;
  logic [AW-1:0]     tail_r, tail_nxt;
  logic [FW-1:0]     fill_r, fill_nxt;
  logic [UNIT_W-1:0] first_r, first_nxt;

  logic              out_valid_r, out_valid_nxt;
  status_t           status_r, status_nxt;
  logic [CP_W-1:0]   dec_r, dec_nxt;
  logic [UNIT_W-1:0] uout_r, uout_nxt;
  logic [1:0]        moved_r, moved_nxt;

  logic              accept;
  logic              is_push, is_head, is_raw;
  logic              two_units, push_invalid, push_full, push_done_first;
  logic              store_empty, need_second;
  logic [FW-1:0]     n_units;
  enc_t              enc;

  logic              mem_we, mem_re;
  logic [UNIT_W-1:0] mem_wdata, mem_rdata;
  logic [AW-1:0]     idx_base, mem_addr;
  step_t             idx_step;

  // Sub-units
  u16rb_codec u_codec (
    .code_point (cp_r),
    .enc        (enc)
  );

  u16rb_idx u_idx (
    .base (idx_base),
    .step (idx_step),
    .idx  (mem_addr)
  );

  u16rb_ram u_ram (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // Command decode and checks
  assign accept       = start && !busy;
  assign is_push      = !cmd_r[1];
  assign is_head      = (cmd_r == CMD_PUSH_CP_HEAD) || (cmd_r == CMD_POP_CP_HEAD) ||
                        (cmd_r == CMD_PUSH_U_HEAD)  || (cmd_r == CMD_POP_U_HEAD);
  assign is_raw       = cmd_r[2];
  assign two_units    = !is_raw && enc.pair;
  assign n_units      = two_units ? FW'(2) : FW'(1);
  assign push_invalid = !is_raw && enc.invalid;
  assign push_full    = fill_r > (FW'(DEPTH) - n_units);
  assign push_done_first = push_invalid || push_full || !two_units;
  assign store_empty  = (fill_r == '0);

  // A code point pop whose first unit opens a pair and a second unit is held
  always_comb begin
    need_second = 1'b0;
    if (!is_raw && (fill_r >= FW'(2))) begin
      need_second = is_head ? is_high(mem_rdata) : is_low(mem_rdata);
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_FIRST;
      end
      S_FIRST: begin
        if (is_push) begin
          state_nxt = push_done_first ? S_IDLE : S_SECOND;
        end else begin
          state_nxt = store_empty ? S_IDLE : S_EXAM;
        end
      end
      S_SECOND: state_nxt = S_IDLE;
      S_EXAM:   state_nxt = need_second ? S_EXAM2 : S_IDLE;
      S_EXAM2:  state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Datapath control and results
  always_comb begin
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_wdata     = '0;
    idx_base      = tail_r;
    idx_step      = STEP_P0;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    fill_nxt      = fill_r;
    first_nxt     = first_r;
    out_valid_nxt = 1'b0;
    status_nxt    = status_r;
    dec_nxt       = dec_r;
    uout_nxt      = uout_r;
    moved_nxt     = moved_r;

    unique case (state_r)
      S_IDLE: begin
      end

      S_FIRST: begin
        if (is_push) begin
          if (push_invalid || push_full) begin
            out_valid_nxt = 1'b1;
            status_nxt    = push_invalid ? ST_INVALID : ST_FULL;
            dec_nxt       = '0;
            uout_nxt      = '0;
            moved_nxt     = '0;
          end else begin
            // first write: tail end gets u0, head end gets the last unit
            mem_we = 1'b1;
            if (is_head) begin
              idx_base  = head_r;
              idx_step  = STEP_M1;
              mem_wdata = is_raw ? uin_r : (two_units ? enc.u1 : enc.u0);
            end else begin
              idx_base  = tail_r;
              idx_step  = STEP_P0;
              mem_wdata = is_raw ? uin_r : enc.u0;
            end
            if (!two_units) begin
              out_valid_nxt = 1'b1;
              status_nxt    = ST_OK;
              dec_nxt       = '0;
              uout_nxt      = '0;
              moved_nxt     = 2'd1;
              fill_nxt      = fill_r + FW'(1);
              if (is_head) head_nxt = head_r - AW'(1);
              else         tail_nxt = tail_r + AW'(1);
            end
          end
        end else begin
          if (store_empty) begin
            out_valid_nxt = 1'b1;
            status_nxt    = ST_SHORT;
            dec_nxt       = '0;
            uout_nxt      = '0;
            moved_nxt     = '0;
          end else begin
            // read the end unit
            mem_re   = 1'b1;
            idx_base = is_head ? head_r : tail_r;
            idx_step = is_head ? STEP_P0 : STEP_M1;
          end
        end
      end

      S_SECOND: begin
        // second unit of a pair push
        mem_we = 1'b1;
        if (is_head) begin
          idx_base  = head_r;
          idx_step  = STEP_M2;
          mem_wdata = enc.u0;
          head_nxt  = head_r - AW'(2);
        end else begin
          idx_base  = tail_r;
          idx_step  = STEP_P1;
          mem_wdata = enc.u1;
          tail_nxt  = tail_r + AW'(2);
        end
        fill_nxt      = fill_r + FW'(2);
        out_valid_nxt = 1'b1;
        status_nxt    = ST_OK;
        dec_nxt       = '0;
        uout_nxt      = '0;
        moved_nxt     = 2'd2;
      end

      S_EXAM: begin
        dec_nxt  = '0;
        uout_nxt = '0;
        if (is_raw) begin
          out_valid_nxt = 1'b1;
          status_nxt    = ST_OK;
          uout_nxt      = mem_rdata;
          moved_nxt     = 2'd1;
          fill_nxt      = fill_r - FW'(1);
          if (is_head) head_nxt = head_r + AW'(1);
          else         tail_nxt = tail_r - AW'(1);
        end else if (need_second) begin
          first_nxt = mem_rdata;
          mem_re    = 1'b1;
          idx_base  = is_head ? head_r : tail_r;
          idx_step  = is_head ? STEP_P1 : STEP_M2;
        end else if ((is_head && is_low(mem_rdata)) || (!is_head && is_high(mem_rdata))) begin
          // wrong surrogate at this end
          out_valid_nxt = 1'b1;
          status_nxt    = ST_MALFORMED;
          moved_nxt     = '0;
        end else if (is_high(mem_rdata) || is_low(mem_rdata)) begin
          // pair start with only one unit held
          out_valid_nxt = 1'b1;
          status_nxt    = ST_SHORT;
          moved_nxt     = '0;
        end else begin
          out_valid_nxt = 1'b1;
          status_nxt    = ST_OK;
          dec_nxt       = {5'd0, mem_rdata};
          moved_nxt     = 2'd1;
          fill_nxt      = fill_r - FW'(1);
          if (is_head) head_nxt = head_r + AW'(1);
          else         tail_nxt = tail_r - AW'(1);
        end
      end

      S_EXAM2: begin
        out_valid_nxt = 1'b1;
        uout_nxt      = '0;
        if ((is_head && is_low(mem_rdata)) || (!is_head && is_high(mem_rdata))) begin
          status_nxt = ST_OK;
          dec_nxt    = is_head ? pair_value(first_r, mem_rdata)
                               : pair_value(mem_rdata, first_r);
          moved_nxt  = 2'd2;
          fill_nxt   = fill_r - FW'(2);
          if (is_head) head_nxt = head_r + AW'(2);
          else         tail_nxt = tail_r - AW'(2);
        end else begin
          status_nxt = ST_MALFORMED;
          dec_nxt    = '0;
          moved_nxt  = '0;
        end
      end

      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= cmd_t'(in_command);
      cp_r  <= in_code_point;
      uin_r <= in_unit_in;
    end
    first_r  <= first_nxt;
    status_r <= status_nxt;
    dec_r    <= dec_nxt;
    uout_r   <= uout_nxt;
    moved_r  <= moved_nxt;
  end

  // Ports
  assign busy              = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_decoded_point = dec_r;
  assign out_unit_out      = uout_r;
  assign out_units_moved   = moved_r;
  assign out_fill_level    = fill_r;

endmodule

// ===== sim/utf16_double_ended_ring_buffer_tb.sv =====
// ----------------------------------------------------------------------------
// utf16_double_ended_ring_buffer_tb
// Self-checking bench for the UTF-16 deque store. It runs a directed table
// with the empty, invalid, pair and malformed cases, then random traffic.
// A predictor tracks head, tail, fill and contents and checks every result
// strobe field by field.
// ----------------------------------------------------------------------------
module utf16_double_ended_ring_buffer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import u16rb_pkg::*;

  localparam int WATCHDOG_CYCLES = 1000;
  localparam int RANDOM_ITEMS    = 400;
  localparam int SHOWN_ERRORS    = 10;

  // One result as the block reports it
  typedef struct packed {
    status_t           st;
    logic [CP_W-1:0]   cp_out;
    logic [UNIT_W-1:0] word_out;
    logic [1:0]        moved;
    logic [FW-1:0]     fill;
  } result_t;

  // One row of the directed table
  typedef struct {
    cmd_t              c;
    logic [CP_W-1:0]   cp;
    logic [UNIT_W-1:0] u;
    bit                typed;
    result_t           r;
  } row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [2:0]        in_command = '0;
  logic [CP_W-1:0]   in_code_point = '0;
  logic [UNIT_W-1:0] in_unit_in = '0;
  logic              out_valid;
  logic [2:0]        out_status;
  logic [CP_W-1:0]   out_decoded_point;
  logic [UNIT_W-1:0] out_unit_out;
  logic [1:0]        out_units_moved;
  logic [FW-1:0]     out_fill_level;

  // Predicted ring contents and pointers
  logic [UNIT_W-1:0] ring_mem [DEPTH];
  logic [AW-1:0]     ring_head = '0;
  logic [AW-1:0]     ring_tail = '0;
  int                ring_fill = 0;

  result_t pending_q [$];
  row_t    dir_rows [$];
  int      taken_count = 0;
  int      fail_count = 0;
  int      quiet_cycles = 0;
  bit      idle_on = 1'b1;

  // Typed expectation for the directed row on the bus
  bit      row_typed = 1'b0;
  result_t row_want;

  utf16_double_ended_ring_buffer u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_command        (in_command),
    .in_code_point     (in_code_point),
    .in_unit_in        (in_unit_in),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_decoded_point (out_decoded_point),
    .out_unit_out      (out_unit_out),
    .out_units_moved   (out_units_moved),
    .out_fill_level    (out_fill_level)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic bit is_lead(input logic [UNIT_W-1:0] w);
    return w >= 16'hD800 && w <= 16'hDBFF;
  endfunction

  function automatic bit is_trail(input logic [UNIT_W-1:0] w);
    return w >= 16'hDC00 && w <= 16'hDFFF;
  endfunction

  function automatic logic [CP_W-1:0] join_pair(input logic [UNIT_W-1:0] a,
                                                input logic [UNIT_W-1:0] b);
    int v;
    v = 'h10000 + ((int'(a) - 'hD800) << 10) + (int'(b) - 'hDC00);
    return CP_W'(v);
  endfunction

  // Apply one command to the predicted deque and return its result
  function automatic result_t deque_apply(input cmd_t c, input logic [CP_W-1:0] cp,
                                          input logic [UNIT_W-1:0] u);
    result_t           r;
    logic [UNIT_W-1:0] w0, w1, a, b;
    logic [CP_W-1:0]   off;
    int                n;
    r = '0;
    r.st = ST_OK;
    n = 1;
    w0 = u;
    w1 = '0;
    case (c)
      CMD_PUSH_CP_TAIL, CMD_PUSH_CP_HEAD, CMD_PUSH_U_TAIL, CMD_PUSH_U_HEAD: begin
        if (c == CMD_PUSH_CP_TAIL || c == CMD_PUSH_CP_HEAD) begin
          off = cp - 21'h10000;
          // validity is checked before room
          if (cp > 21'h10FFFF || (cp >= 21'hD800 && cp <= 21'hDFFF)) begin
            r.st = ST_INVALID;
          end else if (cp < 21'h10000) begin
            w0 = cp[UNIT_W-1:0];
          end else begin
            n = 2;
            w0 = {6'b110110, off[19:10]};
            w1 = {6'b110111, off[9:0]};
          end
        end
        if (r.st == ST_OK && ring_fill + n > DEPTH) r.st = ST_FULL;
        if (r.st == ST_OK) begin
          if (c == CMD_PUSH_CP_TAIL || c == CMD_PUSH_U_TAIL) begin
            ring_mem[ring_tail] = w0;
            if (n == 2) ring_mem[AW'(ring_tail + 1)] = w1;
            ring_tail = AW'(ring_tail + n);
          end else begin
            ring_head = AW'(ring_head - n);
            ring_mem[ring_head] = w0;
            if (n == 2) ring_mem[AW'(ring_head + 1)] = w1;
          end
          ring_fill += n;
        end
      end
      CMD_POP_CP_HEAD: begin
        a = ring_mem[ring_head];
        b = ring_mem[AW'(ring_head + 1)];
        if (ring_fill == 0) r.st = ST_SHORT;
        else if (is_trail(a)) r.st = ST_MALFORMED;
        else if (!is_lead(a)) r.cp_out = CP_W'(a);
        else if (ring_fill < 2) r.st = ST_SHORT;
        else if (!is_trail(b)) r.st = ST_MALFORMED;
        else begin
          r.cp_out = join_pair(a, b);
          n = 2;
        end
        if (r.st == ST_OK) begin
          ring_head = AW'(ring_head + n);
          ring_fill -= n;
        end
      end
      CMD_POP_CP_TAIL: begin
        b = ring_mem[AW'(ring_tail - 1)];
        a = ring_mem[AW'(ring_tail - 2)];
        if (ring_fill == 0) r.st = ST_SHORT;
        else if (is_lead(b)) r.st = ST_MALFORMED;
        else if (!is_trail(b)) r.cp_out = CP_W'(b);
        else if (ring_fill < 2) r.st = ST_SHORT;
        else if (!is_lead(a)) r.st = ST_MALFORMED;
        else begin
          r.cp_out = join_pair(a, b);
          n = 2;
        end
        if (r.st == ST_OK) begin
          ring_tail = AW'(ring_tail - n);
          ring_fill -= n;
        end
      end
      CMD_POP_U_HEAD: begin
        if (ring_fill == 0) begin
          r.st = ST_SHORT;
        end else begin
          r.word_out = ring_mem[ring_head];
          ring_head = AW'(ring_head + 1);
          ring_fill -= 1;
        end
      end
      default: begin
        if (ring_fill == 0) begin
          r.st = ST_SHORT;
        end else begin
          ring_tail = AW'(ring_tail - 1);
          r.word_out = ring_mem[ring_tail];
          ring_fill -= 1;
        end
      end
    endcase
    if (r.st == ST_OK) r.moved = 2'(n);
    r.fill = FW'(ring_fill);
    return r;
  endfunction

  // Accept items, check results, watch for a stall
  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (rst_n) begin
      if (out_valid) begin
        got = '{status_t'(out_status), out_decoded_point, out_unit_out,
                out_units_moved, out_fill_level};
        if (pending_q.size() == 0) begin
          fail_count++;
          if (fail_count <= SHOWN_ERRORS)
            $display("ERROR: unexpected result st=%0d cp=%h u=%h mv=%0d fill=%0d",
                     got.st, got.cp_out, got.word_out, got.moved, got.fill);
        end else begin
          want = pending_q.pop_front();
          if (got.st !== want.st || got.cp_out !== want.cp_out ||
              got.word_out !== want.word_out || got.moved !== want.moved ||
              got.fill !== want.fill) begin
            fail_count++;
            if (fail_count <= SHOWN_ERRORS)
              $display({"ERROR: result mismatch exp st=%0d cp=%h u=%h mv=%0d fill=%0d",
                        " got st=%0d cp=%h u=%h mv=%0d fill=%0d"},
                       want.st, want.cp_out, want.word_out, want.moved, want.fill,
                       got.st, got.cp_out, got.word_out, got.moved, got.fill);
          end
        end
      end
      if (start && !busy) begin
        want = deque_apply(cmd_t'(in_command), in_code_point, in_unit_in);
        pending_q.push_back(row_typed ? row_want : want);
        taken_count++;
      end
      if ((start && !busy) || out_valid) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Drive one item from a falling edge, return at the falling edge after it is taken
  task automatic send_cmd(input cmd_t c, input logic [CP_W-1:0] cp,
                          input logic [UNIT_W-1:0] u);
    int taken0;
    while (idle_on && $urandom_range(99) < 21) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_command <= c;
    in_code_point <= cp;
    in_unit_in <= u;
    taken0 = taken_count;
    do @(negedge clk); while (taken_count == taken0);
  endtask

  task automatic add_row(input cmd_t c, input logic [CP_W-1:0] cp,
                         input logic [UNIT_W-1:0] u, input bit typed, input status_t st,
                         input logic [CP_W-1:0] cp_out, input logic [UNIT_W-1:0] word_out,
                         input logic [1:0] moved, input logic [FW-1:0] fill);
    row_t row;
    row.c = c;
    row.cp = cp;
    row.u = u;
    row.typed = typed;
    row.r = '{st, cp_out, word_out, moved, fill};
    dir_rows.push_back(row);
  endtask

  // Code point mix: all plane ranges, edges, and some invalid values
  function automatic logic [CP_W-1:0] pick_point();
    case ($urandom_range(9))
      0: return CP_W'($urandom_range(32'h7F));
      1: return CP_W'($urandom_range(32'hD7FF, 32'h80));
      2: return CP_W'($urandom_range(32'hFFFF, 32'hE000));
      3, 4, 5: return CP_W'($urandom_range(32'h10FFFF, 32'h10000));
      6: begin
        case ($urandom_range(5))
          0: return 21'h0;
          1: return 21'hD7FF;
          2: return 21'hE000;
          3: return 21'hFFFF;
          4: return 21'h10000;
          default: return 21'h10FFFF;
        endcase
      end
      7: return CP_W'($urandom_range(32'hDFFF, 32'hD800));
      8: return CP_W'($urandom_range(32'h1FFFFF, 32'h110000));
      default: return CP_W'($urandom);
    endcase
  endfunction

  // Raw units lean toward surrogates to provoke malformed pops
  function automatic logic [UNIT_W-1:0] pick_unit();
    if ($urandom_range(99) < 35) return UNIT_W'($urandom_range(32'hDFFF, 32'hD800));
    return UNIT_W'($urandom);
  endfunction

  task automatic send_random(input int push_pct);
    bit                push, raw, tail;
    cmd_t              c;
    logic [CP_W-1:0]   cp;
    logic [UNIT_W-1:0] u;
    push = $urandom_range(99) < push_pct;
    raw = $urandom_range(99) < 25;
    tail = 1'($urandom_range(1));
    if (push) c = raw ? (tail ? CMD_PUSH_U_TAIL : CMD_PUSH_U_HEAD)
                      : (tail ? CMD_PUSH_CP_TAIL : CMD_PUSH_CP_HEAD);
    else c = raw ? (tail ? CMD_POP_U_TAIL : CMD_POP_U_HEAD)
                 : (tail ? CMD_POP_CP_TAIL : CMD_POP_CP_HEAD);
    cp = (push && !raw) ? pick_point() : CP_W'($urandom);
    u = (push && raw) ? pick_unit() : UNIT_W'($urandom);
    send_cmd(c, cp, u);
  endtask

  initial begin
    // Directed table: typed rows carry their result, the rest use the predictor
    add_row(CMD_POP_CP_HEAD,  21'h0,      16'h0,    1, ST_SHORT,     21'h0,      16'h0,    0, 0);
    add_row(CMD_POP_U_TAIL,   21'h0,      16'hFFFF, 1, ST_SHORT,     21'h0,      16'h0,    0, 0);
    add_row(CMD_PUSH_CP_TAIL, 21'h110000, 16'h0,    1, ST_INVALID,   21'h0,      16'h0,    0, 0);
    add_row(CMD_PUSH_CP_HEAD, 21'h1FFFFF, 16'hFFFF, 1, ST_INVALID,   21'h0,      16'h0,    0, 0);
    add_row(CMD_PUSH_CP_TAIL, 21'hDFFF,   16'h0,    1, ST_INVALID,   21'h0,      16'h0,    0, 0);
    add_row(CMD_PUSH_CP_TAIL, 21'h0,      16'hFFFF, 1, ST_OK,        21'h0,      16'h0,    1, 1);
    add_row(CMD_PUSH_CP_TAIL, 21'h10FFFF, 16'h0,    1, ST_OK,        21'h0,      16'h0,    2, 3);
    add_row(CMD_PUSH_CP_HEAD, 21'h10000,  16'h0,    1, ST_OK,        21'h0,      16'h0,    2, 5);
    add_row(CMD_PUSH_CP_HEAD, 21'hFFFF,   16'h0,    1, ST_OK,        21'h0,      16'h0,    1, 6);
    add_row(CMD_POP_CP_TAIL,  21'h0,      16'h0,    1, ST_OK,        21'h10FFFF, 16'h0,    2, 4);
    add_row(CMD_POP_CP_HEAD,  21'h0,      16'h0,    1, ST_OK,        21'hFFFF,   16'h0,    1, 3);
    add_row(CMD_POP_CP_HEAD,  21'h0,      16'h0,    1, ST_OK,        21'h10000,  16'h0,    2, 1);
    add_row(CMD_POP_U_HEAD,   21'h0,      16'h0,    1, ST_OK,        21'h0,      16'h0,    1, 0);
    add_row(CMD_PUSH_U_TAIL,  21'h0,      16'hDC00, 1, ST_OK,        21'h0,      16'h0,    1, 1);
    // low surrogate at the head
    add_row(CMD_POP_CP_HEAD,  21'h0,      16'h0,    1, ST_MALFORMED, 21'h0,      16'h0,    0, 1);
    // low surrogate at the tail with nothing before it
    add_row(CMD_POP_CP_TAIL,  21'h0,      16'h0,    1, ST_SHORT,     21'h0,      16'h0,    0, 1);
    add_row(CMD_PUSH_U_HEAD,  21'h0,      16'hDBFF, 1, ST_OK,        21'h0,      16'h0,    1, 2);
    add_row(CMD_POP_CP_TAIL,  21'h0,      16'h0,    0, ST_OK,        21'h0,      16'h0,    0, 0);
    add_row(CMD_PUSH_U_TAIL,  21'h0,      16'hDBFF, 1, ST_OK,        21'h0,      16'h0,    1, 1);
    // lone high surrogate: short at the head, malformed at the tail
    add_row(CMD_POP_CP_HEAD,  21'h0,      16'h0,    1, ST_SHORT,     21'h0,      16'h0,    0, 1);
    add_row(CMD_POP_CP_TAIL,  21'h0,      16'h0,    1, ST_MALFORMED, 21'h0,      16'h0,    0, 1);
    add_row(CMD_PUSH_U_TAIL,  21'h0,      16'hFFFF, 0, ST_OK,        21'h0,      16'h0,    0, 0);
    // high surrogate followed by a non-surrogate
    add_row(CMD_POP_CP_HEAD,  21'h0,      16'h0,    1, ST_MALFORMED, 21'h0,      16'h0,    0, 2);
    add_row(CMD_PUSH_U_TAIL,  21'h0,      16'hDFFF, 0, ST_OK,        21'h0,      16'h0,    0, 0);
    // low surrogate preceded by a non-surrogate
    add_row(CMD_POP_CP_TAIL,  21'h0,      16'h0,    1, ST_MALFORMED, 21'h0,      16'h0,    0, 3);
    add_row(CMD_POP_U_TAIL,   21'h0,      16'h0,    0, ST_OK,        21'h0,      16'h0,    0, 0);
    add_row(CMD_POP_U_TAIL,   21'h0,      16'h0,    0, ST_OK,        21'h0,      16'h0,    0, 0);
    add_row(CMD_POP_U_HEAD,   21'h0,      16'h0,    0, ST_OK,        21'h0,      16'h0,    0, 0);

    // Reset
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part
    foreach (dir_rows[i]) begin
      row_typed = dir_rows[i].typed;
      row_want = dir_rows[i].r;
      send_cmd(dir_rows[i].c, dir_rows[i].cp, dir_rows[i].u);
    end
    row_typed = 1'b0;

    // Random mix, with a stretch of back-to-back items in the middle
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      idle_on = !(k >= 150 && k < 250);
      send_random(55);
    end
    idle_on = 1'b1;
    start <= 1'b0;

    // Wait for outstanding results, then a short tail
    while (pending_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/u16rb_pkg.sv
sv/u16rb_ram.sv
sv/u16rb_idx.sv
sv/u16rb_codec.sv
sv/utf16_double_ended_ring_buffer.sv
sim/utf16_double_ended_ring_buffer_tb.sv
